[rtl/core/fnq_pkg.sv]
// Package for the frequency-to-note quantizer: tuning tables, pitch lookup, register codes.
package fnq_pkg;

  localparam int NOTE_COUNT_DEF = 128;
  localparam int NOTE_IDX_W     = 7;
  localparam int FREQ_W         = 24;
  localparam int GAIN_W         = 20;
  localparam int BASE_W         = 22;
  localparam int TEMPER_ROWS    = 9;
  localparam int TOP_GROUP      = 10;
  localparam int CFG_INDEX_W    = 4;
  localparam int CFG_DATA_W     = 24;
  localparam int OUT_DATA_W     = 64;

  // register indexes on the configuration channel
  localparam logic [CFG_INDEX_W-1:0] REG_TEMPERAMENT    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSPOSE_GAIN = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCKED_NOTE    = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FREQ_FLOOR     = 4'd3;

  localparam logic [3:0]        TEMPER_RESET = 4'd0;
  localparam logic [GAIN_W-1:0] GAIN_RESET   = 20'd65536;
  localparam logic [4:0]        LOCK_RESET   = 5'h1F;
  localparam logic [FREQ_W-1:0] MIN_F_RESET  = 24'd5120;
  localparam logic [3:0]        LOCK_MAX     = 4'd11;

  typedef logic [0:11][BASE_W-1:0]              equal_row_t;
  typedef logic [0:7][0:11][15:0]               centi_tab_t;
  typedef logic [0:TEMPER_ROWS-1][0:11][BASE_W-1:0] base_tab_t;

  // equal temperament, group 5, in 1/8192 Hz
  localparam equal_row_t EQUAL_BASE = '{
    22'd2143237, 22'd2270680, 22'd2405702, 22'd2548752, 22'd2700309, 22'd2860878,
    22'd3030994, 22'd3211227, 22'd3402176, 22'd3604480, 22'd3818814, 22'd4045892
  };

  // historical temperaments, group 5, in 1/100 Hz
  localparam centi_tab_t HIST_CENTI = '{
    '{16'd26074, 16'd27844, 16'd29333, 16'd30903, 16'd33000, 16'd34765,
      16'd37125, 16'd39111, 16'd41766, 16'd44000, 16'd46354, 16'd49500},
    '{16'd26276, 16'd27687, 16'd29430, 16'd31146, 16'd32870, 16'd35037,
      16'd36918, 16'd39370, 16'd41530, 16'd44000, 16'd46718, 16'd49226},
    '{16'd26318, 16'd27726, 16'd29425, 16'd31192, 16'd32898, 16'd35091,
      16'd37010, 16'd39355, 16'd41589, 16'd44000, 16'd46788, 16'd49347},
    '{16'd26340, 16'd27750, 16'd29433, 16'd31218, 16'd33000, 16'd35121,
      16'd36999, 16'd39377, 16'd41624, 16'd44000, 16'd46827, 16'd49500},
    '{16'd26277, 16'd27683, 16'd29277, 16'd31203, 16'd33000, 16'd35036,
      16'd37053, 16'd39339, 16'd41524, 16'd44000, 16'd46805, 16'd49500},
    '{16'd26318, 16'd27671, 16'd29425, 16'd31031, 16'd32898, 16'd35200,
      16'd36895, 16'd39355, 16'd41507, 16'd44000, 16'd46739, 16'd49193},
    '{16'd26400, 16'd27500, 16'd29700, 16'd31680, 16'd33000, 16'd35200,
      16'd37125, 16'd39600, 16'd41250, 16'd44000, 16'd47520, 16'd49500},
    '{16'd26318, 16'd27500, 16'd29425, 16'd31484, 16'd32898, 16'd35200,
      16'd36781, 16'd39355, 16'd41122, 16'd44000, 16'd47079, 16'd49193}
  };

  // build the full base table at elaboration; historical rows round c * 8192 / 100
  function automatic base_tab_t build_base();
    base_tab_t  tab;
    logic [31:0] scaled;
    for (int r = 0; r < TEMPER_ROWS; r++) begin
      for (int c = 0; c < 12; c++) begin
        if (r == 0) begin
          tab[r][c] = EQUAL_BASE[c];
        end else begin
          scaled    = (32'(HIST_CENTI[r-1][c]) * 32'd8192 + 32'd50) / 32'd100;
          tab[r][c] = scaled[BASE_W-1:0];
        end
      end
    end
    return tab;
  endfunction

  localparam base_tab_t BASE_TAB = build_base();

  // x / 12 for x below 128: multiply by 43, drop nine bits
  function automatic logic [3:0] div12(logic [NOTE_IDX_W-1:0] x);
    logic [12:0] prod;
    prod = 13'(x) * 13'd43;
    return prod[12:9];
  endfunction

  // pitch of note i in 1/256 Hz: base of its class shifted down by its octave group
  function automatic logic [FREQ_W-1:0] pitch_at(logic [3:0] t, logic [NOTE_IDX_W-1:0] i);
    logic [3:0]        g;
    logic [3:0]        pc;
    logic [3:0]        row;
    logic [BASE_W-1:0] base;
    g    = div12(i);
    pc   = 4'(i - 7'(g) * 7'd12);
    row  = (t >= 4'd1 && t <= 4'd8) ? t : 4'd0;
    base = BASE_TAB[row][pc];
    return FREQ_W'(base >> (4'(TOP_GROUP) - g));
  endfunction

endpackage

[rtl/core/frequency_to_note_quantizer.sv]
// Top level of the frequency-to-note quantizer: a pipelined nearest-note search.
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+------------------------------------------
//  s_      | in  | s_tvalid / s_tready  | freq_in, 24 bits, 1/256 Hz
//  m_      | out | m_tvalid / m_tready  | valid_res, class, octave, note, pitch, freq
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index selects register, cfg_data value
//
// One word enters per cycle while no stall at m_ holds it back; the binary search does
// one table probe and compare per stage.
// Each stage holds its own valid bit and advances when it is empty or the stage
// after it advances, so bubbles close up and a stall at m_ holds every word.
// Reset (rst, synchronous) clears all valid bits and loads the register defaults;
// s_tready is high in the first cycle after reset. cfg_ready is always high.
module frequency_to_note_quantizer
  import fnq_pkg::*;
#(
  parameter int NOTE_COUNT = NOTE_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [FREQ_W-1:0]      s_tdata,   // [23:0] freq_in
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,   // [0] valid_res, [4:1] pitch_class,
                                            // [8:5] octave_number, [15:9] note_index,
                                            // [39:16] reference_pitch, [63:40] scaled_freq
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IW      = $clog2(NOTE_COUNT);
  localparam int SRCH0   = 3;            // first search stage
  localparam int PICK    = SRCH0 + IW;   // nearer of the two neighbors
  localparam int LOCK    = PICK + 1;     // edge reject and locked class
  localparam int NS      = LOCK + 2;     // last stage is the output register
  localparam logic [IW-1:0] SRCH_MAX = IW'(NOTE_COUNT - 2);
  localparam logic [IW-1:0] LAST_IDX = IW'(NOTE_COUNT - 1);

  typedef struct packed {
    logic [FREQ_W-1:0] s;          // input frequency in stage 0, scaled after
    logic              rej;
    logic [IW-1:0]     idx;        // search position, then chosen note
    logic [3:0]        pc;
    logic [3:0]        oct;
    logic [FREQ_W-1:0] ref_pitch;
  } stage_t;

  // configuration registers
  logic [3:0]        temperament;
  logic [GAIN_W-1:0] transpose_gain;
  logic [4:0]        locked_note;
  logic [FREQ_W-1:0] freq_floor;

  stage_t pipe [NS];
  stage_t pipe_next [NS];
  logic   v [NS];
  logic   adv [NS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temperament    <= TEMPER_RESET;
      transpose_gain <= GAIN_RESET;
      locked_note    <= LOCK_RESET;
      freq_floor     <= MIN_F_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TEMPERAMENT:    temperament    <= cfg_data[3:0];
        REG_TRANSPOSE_GAIN: transpose_gain <= cfg_data[GAIN_W-1:0];
        REG_LOCKED_NOTE:    locked_note    <= cfg_data[4:0];
        REG_FREQ_FLOOR:     freq_floor     <= cfg_data[FREQ_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // advance chain: a stage moves when empty or when its successor moves
  assign adv[NS-1] = !v[NS-1] || m_tready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_adv
    assign adv[k] = !v[k] || adv[k+1];
  end
  assign s_tready = adv[0];

  always_comb begin
    logic [GAIN_W+FREQ_W:0] prod;
    logic [IW-1:0]          cand;
    logic [FREQ_W-1:0]      p_lo;
    logic [FREQ_W-1:0]      p_hi;
    logic [IW-1:0]          nxt_idx;
    logic [3:0]             g;
    logic [3:0]             pc;
    logic [3:0]             n;
    logic [3:0]             d1;
    logic [4:0]             d2;
    logic [3:0]             oct;
    logic [7:0]             lidx;

    // stage 0: capture the word, flag it below the minimum
    pipe_next[0]     = '0;
    pipe_next[0].s   = s_tdata;
    pipe_next[0].rej = s_tdata < freq_floor;

    // stage 1: transpose with rounding, saturate to 24 bits
    pipe_next[1] = pipe[0];
    prod = (GAIN_W+FREQ_W+1)'(pipe[0].s) * (GAIN_W+FREQ_W+1)'(transpose_gain)
         + (GAIN_W+FREQ_W+1)'(32768);
    pipe_next[1].s = (|prod[GAIN_W+FREQ_W:FREQ_W+16]) ? {FREQ_W{1'b1}}
                                                       : prod[FREQ_W+15:16];

    // stage 2: reject outside the table, start the search at note 0
    pipe_next[2]     = pipe[1];
    pipe_next[2].idx = '0;
    pipe_next[2].rej = pipe[1].rej
                     || pipe[1].s > pitch_at(temperament, NOTE_IDX_W'(LAST_IDX))
                     || pipe[1].s <= pitch_at(temperament, '0);

    // search stages: find the highest note whose pitch is still below s, one bit each
    for (int k = 0; k < IW; k++) begin
      pipe_next[SRCH0+k] = pipe[SRCH0+k-1];
      cand = pipe[SRCH0+k-1].idx | (IW'(1) << (IW - 1 - k));
      if (cand <= SRCH_MAX
          && pitch_at(temperament, NOTE_IDX_W'(cand)) < pipe[SRCH0+k-1].s) begin
        pipe_next[SRCH0+k].idx = cand;
      end
    end

    // pick the nearer neighbor; a tie keeps the lower note
    pipe_next[PICK] = pipe[PICK-1];
    nxt_idx = pipe[PICK-1].idx + IW'(1);
    p_lo = pitch_at(temperament, NOTE_IDX_W'(pipe[PICK-1].idx));
    p_hi = pitch_at(temperament, NOTE_IDX_W'(nxt_idx));
    if ((p_hi - pipe[PICK-1].s) < (pipe[PICK-1].s - p_lo)) begin
      pipe_next[PICK].idx = nxt_idx;
    end

    // drop edge notes; a locked class takes the nearer of this group and the next (tie up)
    pipe_next[LOCK] = pipe[LOCK-1];
    g  = div12(NOTE_IDX_W'(pipe[LOCK-1].idx));
    pc = 4'(NOTE_IDX_W'(pipe[LOCK-1].idx) - 7'(g) * 7'd12);
    n  = locked_note[3:0];
    d1 = (pc > n) ? pc - n : n - pc;
    d2 = 5'd12 + 5'(n) - 5'(pc);
    oct  = ({1'b0, d1} < d2) ? g : g + 4'd1;
    lidx = 8'(oct) * 8'd12 + 8'(n);
    pipe_next[LOCK].rej = pipe[LOCK-1].rej || pipe[LOCK-1].idx == '0
                        || pipe[LOCK-1].idx == LAST_IDX;
    if (locked_note <= 5'(LOCK_MAX)) begin
      pipe_next[LOCK].pc  = n;
      pipe_next[LOCK].oct = oct;
      pipe_next[LOCK].idx = IW'(lidx);
      if (lidx >= 8'(NOTE_COUNT)) begin
        pipe_next[LOCK].rej = 1'b1;
      end
    end else begin
      pipe_next[LOCK].pc  = pc;
      pipe_next[LOCK].oct = g;
    end

    // output register: fetch the chosen pitch, zero the note fields of a rejected word
    pipe_next[NS-1] = pipe[NS-2];
    pipe_next[NS-1].ref_pitch = pitch_at(temperament, NOTE_IDX_W'(pipe[NS-2].idx));
    if (pipe[NS-2].rej) begin
      pipe_next[NS-1].idx       = '0;
      pipe_next[NS-1].pc        = '0;
      pipe_next[NS-1].oct       = '0;
      pipe_next[NS-1].ref_pitch = '0;
    end
  end

  always_ff @(posedge clk) begin
    // first stage takes the input word
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv[0]) begin
      v[0] <= s_tvalid;
    end
    if (adv[0] && s_tvalid) begin
      pipe[0] <= pipe_next[0];
    end
    // later stages take from their predecessor
    for (int k = 1; k < NS; k++) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv[k]) begin
        v[k] <= v[k-1];
      end
      if (adv[k] && v[k-1]) begin
        pipe[k] <= pipe_next[k];
      end
    end
  end

  assign m_tvalid = v[NS-1];
  assign m_tdata  = {pipe[NS-1].s,
                     pipe[NS-1].ref_pitch,
                     NOTE_IDX_W'(pipe[NS-1].idx),
                     pipe[NS-1].oct,
                     pipe[NS-1].pc,
                     !pipe[NS-1].rej};

  // an empty output register means the whole chain can advance
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register is empty");

  // a found note agrees with its class and octave
  a_note_split: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0]
      |-> m_tdata[15:9] == 7'(m_tdata[8:5]) * 7'd12 + 7'(m_tdata[4:1]))
    else $error("note index does not match class and octave");

  // a rejected word carries no note
  a_reject_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[39:1] == '0)
    else $error("rejected word carries note fields");

endmodule
